FILE: src/doubly_linked_list_manager_assert.svh
// ----------------------------------------------------------------------------
// Doubly linked list manager assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define DLLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`define DLLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DLLM_ASSERT(lbl, clk, rst, prop, msg)
`define DLLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/dllm_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared constants, operation and status codes, item and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package dllm_pkg;

  localparam int NODES_DEF = 64;
  localparam int NODE_W    = 6;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [2:0] {
    FN_ADD_HEAD   = 3'd0,
    FN_ADD_TAIL   = 3'd1,
    FN_ADD_AFTER  = 3'd2,
    FN_ADD_BEFORE = 3'd3,
    FN_REMOVE     = 3'd4,
    FN_POP_HEAD   = 3'd5,
    FN_POP_TAIL   = 3'd6,
    FN_QUERY      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_LINKED  = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    func_t func;
    node_t node;
    node_t ref_node;
  } req_t;

  typedef struct packed {
    node_t   result_node;
    status_t status;
    logic    list_empty;
    logic    node_linked;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic rd2;
    logic wr1;
    logic wr2;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: src/doubly_linked_list_manager.sv
// Sequencing: an item accepted in idle steps through the RD2, WR1 and WR2
// states, and its result is strobed on done as the controller returns to idle.
// No new item is taken until then, because of the two dependent reads and the
// two writes each item makes through the one write port of each link memory.
// Reset: after rst falls, busy stays high for NODES cycles while both link
// memories are swept so that every node points to itself.
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Circular doubly linked list over a fixed node pool with node 0 as anchor.
// ----------------------------------------------------------------------------
`default_nettype none

module doubly_linked_list_manager #(
  parameter int NODES = dllm_pkg::NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire dllm_pkg::req_t req,
  output logic                done,
  output dllm_pkg::rsp_t      rsp
);

  dllm_pkg::ctrl_cmd_t  cmd;
  dllm_pkg::ctrl_stat_t stat;

  dllm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  dllm_datapath #(.NODES(NODES)) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

FILE: src/dllm_ram.sv
// ----------------------------------------------------------------------------
// Generic link RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dllm_ram #(
  parameter int WIDTH = dllm_pkg::NODE_W,
  parameter int DEPTH = dllm_pkg::NODES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/dllm_ctrl.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager controller
// Sequences the clearing pass and the read, read, write, write steps of an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "doubly_linked_list_manager_assert.svh"

module dllm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done,
  output dllm_pkg::ctrl_cmd_t       cmd,
  input  wire dllm_pkg::ctrl_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD2,
    S_WR1,
    S_WR2
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          state <= S_WR1;
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.clr    = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && start;
    cmd.rd2    = (state == S_RD2);
    cmd.wr1    = (state == S_WR1);
    cmd.wr2    = (state == S_WR2);
  end

  `DLLM_ASSERT(a_accept_done, clk, rst, (state == S_IDLE && start) |-> ##4 done, "item not answered")
  `DLLM_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `DLLM_ASSERT_NEXT(a_clear_ends, clk, rst, state == S_CLEAR && stat.clr_last, state == S_IDLE, "clear pass did not end")

endmodule

`default_nettype wire

FILE: src/dllm_datapath.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager datapath
// Link memories, address selection, operation decode and link rewrites.
// ----------------------------------------------------------------------------
`default_nettype none

`include "doubly_linked_list_manager_assert.svh"

module dllm_datapath #(
  parameter int NODES = dllm_pkg::NODES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dllm_pkg::ctrl_cmd_t cmd,
  output dllm_pkg::ctrl_stat_t     stat,
  input  wire dllm_pkg::req_t      req,
  output dllm_pkg::rsp_t           rsp
);

  localparam int IDX_W = $clog2(NODES);

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(NODES - 1);

  function automatic logic in_range(dllm_pkg::node_t v);
    return 32'(v) < NODES;
  endfunction

  function automatic idx_t to_idx(dllm_pkg::node_t v);
    return in_range(v) ? idx_t'(v) : '0;
  endfunction

  idx_t           clr_cnt;
  dllm_pkg::req_t req_q;
  idx_t           d1n;
  idx_t           d1p;
  logic           empty_q;
  dllm_pkg::rsp_t rsp_q;

  logic w2_en;
  idx_t w2n_addr;
  idx_t w2n_data;
  idx_t w2p_addr;
  idx_t w2p_data;

  logic next_we;
  idx_t next_waddr;
  idx_t next_wdata;
  idx_t next_raddr;
  idx_t next_q;
  logic prev_we;
  idx_t prev_waddr;
  idx_t prev_wdata;
  idx_t prev_raddr;
  idx_t prev_q;

  dllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_q)
  );

  dllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_q)
  );

  // Read addresses: the first read is issued from the input ports in the
  // accept cycle, the second from the latched item and the first read data.
  logic is_pop_in;
  logic is_pop_q;
  idx_t pop_r;

  always_comb begin
    is_pop_in = (req.func == dllm_pkg::FN_POP_HEAD) || (req.func == dllm_pkg::FN_POP_TAIL);
    is_pop_q  = (req_q.func == dllm_pkg::FN_POP_HEAD) || (req_q.func == dllm_pkg::FN_POP_TAIL);
    pop_r     = (req_q.func == dllm_pkg::FN_POP_HEAD) ? next_q : prev_q;
    if (cmd.rd2) begin
      if (is_pop_q) begin
        next_raddr = pop_r;
        prev_raddr = pop_r;
      end else begin
        next_raddr = (req_q.func == dllm_pkg::FN_ADD_HEAD) ? '0 : to_idx(req_q.ref_node);
        prev_raddr = '0;
      end
    end else begin
      next_raddr = is_pop_in ? '0 : to_idx(req.node);
      if (is_pop_in || req.func == dllm_pkg::FN_ADD_TAIL) begin
        prev_raddr = '0;
      end else if (req.func == dllm_pkg::FN_ADD_BEFORE) begin
        prev_raddr = to_idx(req.ref_node);
      end else begin
        prev_raddr = to_idx(req.node);
      end
    end
  end

  // Decode of the item once both reads are back.
  logic              q_ok;
  idx_t              qn_idx;
  idx_t              qr_idx;
  logic              lnk_n;
  logic              ref_bad;
  idx_t              add_a;
  idx_t              add_b;
  idx_t              a;
  idx_t              b;
  idx_t              tgt;
  logic              do_splice;
  logic              do_unlink;
  logic              empty_nx;
  logic              linked;
  dllm_pkg::status_t st;
  dllm_pkg::node_t   res;

  always_comb begin
    q_ok    = (req_q.node != '0) && in_range(req_q.node);
    qn_idx  = to_idx(req_q.node);
    qr_idx  = to_idx(req_q.ref_node);
    lnk_n   = (d1n != qn_idx);
    ref_bad = !in_range(req_q.ref_node) ||
              ((req_q.ref_node != '0) && (next_q == qr_idx));
    case (req_q.func)
      dllm_pkg::FN_ADD_HEAD: begin
        add_a = '0;
        add_b = next_q;
      end
      dllm_pkg::FN_ADD_TAIL: begin
        add_a = d1p;
        add_b = '0;
      end
      dllm_pkg::FN_ADD_AFTER: begin
        add_a = qr_idx;
        add_b = next_q;
      end
      default: begin
        add_a = d1p;
        add_b = qr_idx;
      end
    endcase

    st        = dllm_pkg::ST_OK;
    res       = req_q.node;
    linked    = 1'b0;
    empty_nx  = empty_q;
    do_splice = 1'b0;
    do_unlink = 1'b0;
    a         = '0;
    b         = '0;
    tgt       = qn_idx;
    case (req_q.func)
      dllm_pkg::FN_ADD_HEAD, dllm_pkg::FN_ADD_TAIL,
      dllm_pkg::FN_ADD_AFTER, dllm_pkg::FN_ADD_BEFORE: begin
        if (!q_ok) begin
          st = dllm_pkg::ST_INVALID;
        end else if (lnk_n) begin
          st     = dllm_pkg::ST_LINKED;
          linked = 1'b1;
        end else if (ref_bad && (req_q.func == dllm_pkg::FN_ADD_AFTER ||
                                 req_q.func == dllm_pkg::FN_ADD_BEFORE)) begin
          st = dllm_pkg::ST_INVALID;
        end else begin
          do_splice = 1'b1;
          linked    = 1'b1;
          empty_nx  = 1'b0;
          a         = add_a;
          b         = add_b;
        end
      end
      dllm_pkg::FN_REMOVE: begin
        if (!q_ok) begin
          st = dllm_pkg::ST_INVALID;
        end else if (lnk_n) begin
          do_unlink = 1'b1;
          a         = d1p;
          b         = d1n;
          empty_nx  = (d1p == '0) && (d1n == '0);
        end
      end
      dllm_pkg::FN_POP_HEAD, dllm_pkg::FN_POP_TAIL: begin
        if (d1n == '0) begin
          res = '0;
          st  = dllm_pkg::ST_EMPTY;
        end else begin
          // The second read returned the links of the popped node.
          tgt       = (req_q.func == dllm_pkg::FN_POP_HEAD) ? d1n : d1p;
          res       = dllm_pkg::node_t'(tgt);
          do_unlink = 1'b1;
          a         = prev_q;
          b         = next_q;
          empty_nx  = (prev_q == '0) && (next_q == '0);
        end
      end
      default: begin
        if (!in_range(req_q.node)) begin
          st = dllm_pkg::ST_INVALID;
        end
        linked = q_ok && lnk_n;
      end
    endcase
  end

  // Write port selection: clearing pass, then the two rewrite steps.
  always_comb begin
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    if (cmd.clr) begin
      next_we    = 1'b1;
      next_waddr = clr_cnt;
      next_wdata = clr_cnt;
      prev_we    = 1'b1;
      prev_waddr = clr_cnt;
      prev_wdata = clr_cnt;
    end else if (cmd.wr1) begin
      next_we    = do_splice || do_unlink;
      next_waddr = a;
      next_wdata = do_splice ? tgt : b;
      prev_we    = do_splice || do_unlink;
      prev_waddr = do_splice ? tgt : b;
      prev_wdata = a;
    end else if (cmd.wr2) begin
      next_we    = w2_en;
      next_waddr = w2n_addr;
      next_wdata = w2n_data;
      prev_we    = w2_en;
      prev_waddr = w2p_addr;
      prev_wdata = w2p_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      empty_q <= 1'b1;
      w2_en   <= 1'b0;
      rsp_q   <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.wr1) begin
        w2_en    <= do_splice || do_unlink;
        empty_q  <= empty_nx;
        rsp_q    <= '{result_node: res, status: st, list_empty: empty_nx,
                      node_linked: linked};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
    if (cmd.rd2) begin
      d1n <= next_q;
      d1p <= prev_q;
    end
    if (cmd.wr1) begin
      w2n_addr <= tgt;
      w2n_data <= do_splice ? b : tgt;
      w2p_addr <= do_splice ? b : tgt;
      w2p_data <= tgt;
    end
  end

  assign stat.clr_last = (clr_cnt == LAST_IDX);
  assign rsp           = rsp_q;

  `DLLM_ASSERT(a_linked_not_empty, clk, rst, rsp_q.node_linked |-> !rsp_q.list_empty, "linked node in empty list")
  `DLLM_ASSERT(a_empty_status, clk, rst, (rsp_q.status == dllm_pkg::ST_EMPTY) |-> (rsp_q.result_node == '0 && rsp_q.list_empty), "empty status without empty list")
  `DLLM_ASSERT_NEXT(a_clr_step, clk, rst, cmd.clr && !stat.clr_last, clr_cnt == $past(clr_cnt) + 1'b1, "clear counter skipped")

endmodule

`default_nettype wire
